### rtl/core/psmm_pkg.sv
package psmm_pkg;

  localparam int CNT_W = 3;
  localparam int VAL_W = 32;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_LOAD_LEFT = 2'd0,
    OP_LOAD_SYM  = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT   = 2'd0,
    CFG_DIM         = 2'd1,
    CFG_LIST_OFFSET = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic wr_left;
    logic wr_sym;
    logic rd;
    logic k_first;
    logic k_last;
    cnt_t r;
    cnt_t c;
    cnt_t k;
    logic load;
    logic elem_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } status_t;

  // first packed slot of triangle row h
  function automatic logic [5:0] tri_base(input cnt_t h);
    logic [5:0] hw;
    hw = {3'b000, h};
    return 6'((hw * (hw + 6'd1)) >> 1);
  endfunction

endpackage

### rtl/core/packed_symmetric_matrix_multiply_top.sv
// Multiplies a stored left matrix (row_count x dim, signed Q16.16) by a symmetric dim x dim
// matrix kept as its packed lower triangle. A load word (tuser op 0 or 1) writes one element
// and leaves the input ready for the next word; a packed element lands at slot list_index -
// list_offset and is dropped when that falls outside the triangle. A compute word (op 2) emits
// row_count*dim product words in row-major order, tlast on the final one. Each product word
// needs dim reads through the single read port of each store, one multiply stage, one
// accumulate stage and a move into the output register before the next word's reads start;
// a stalled output holds the sequencer. The exact sum is floored by 2^16 and saturated to
// 32 bits. No new word is taken until a compute has placed its last result in the output
// register. Store entries that were never loaded read back undefined.
module packed_symmetric_matrix_multiply_top #(
  parameter int MAX_N = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row_sel[2:0], col_sel[5:3], list_index[13:6], value[45:14]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import psmm_pkg::*;

  logic [3:0] row_count_q, dim_q;
  logic [7:0] list_offset_q;
  cnt_t       rows_m1, dim_m1;
  cmd_t       cmd;
  status_t    status;
  cnt_t       out_row, out_col;
  logic [31:0] out_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= 4'd8;
      dim_q         <= 4'd8;
      list_offset_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_ROW_COUNT:   row_count_q   <= cfg_data_i[3:0];
        CFG_DIM:         dim_q         <= cfg_data_i[3:0];
        CFG_LIST_OFFSET: list_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sizes clamped into 1..MAX_N, kept as last index
  function automatic cnt_t clamp_m1(input logic [3:0] v);
    if (v == 4'd0) begin
      return '0;
    end else if (int'(v) > MAX_N) begin
      return cnt_t'(MAX_N - 1);
    end else begin
      return cnt_t'(v - 4'd1);
    end
  endfunction

  assign rows_m1 = clamp_m1(row_count_q);
  assign dim_m1  = clamp_m1(dim_q);

  psmm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .op_i      (op_e'(s_axis_tuser)),
    .rows_m1_i (rows_m1),
    .dim_m1_i  (dim_m1),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  psmm_dp #(.MAX_N(MAX_N)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .row_sel_i    (s_axis_tdata[2:0]),
    .col_sel_i    (s_axis_tdata[5:3]),
    .list_index_i (s_axis_tdata[13:6]),
    .value_i      (s_axis_tdata[45:14]),
    .list_offset_i(list_offset_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

### rtl/core/psmm_ram.sv
module psmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/psmm_ctrl.sv
module psmm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psmm_pkg::op_e     op_i,
  input  psmm_pkg::cnt_t    rows_m1_i,
  input  psmm_pkg::cnt_t    dim_m1_i,
  input  psmm_pkg::status_t status_i,
  output psmm_pkg::cmd_t    cmd_o
);
  import psmm_pkg::*;

  state_e state_q, state_d;
  cnt_t   r_q, r_d, c_q, c_d, k_q, k_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.r = r_q;
    cmd_o.c = c_q;
    cmd_o.k = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_LOAD_LEFT: cmd_o.wr_left = 1'b1;
            OP_LOAD_SYM:  cmd_o.wr_sym  = 1'b1;
            OP_COMPUTE: begin
              r_d     = '0;
              c_d     = '0;
              k_d     = '0;
              state_d = S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.rd      = 1'b1;
        cmd_o.k_first = (k_q == '0);
        cmd_o.k_last  = (k_q == dim_m1_i);
        if (k_q == dim_m1_i) begin
          k_d     = '0;
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + cnt_t'(1);
        end
      end
      S_DRAIN: begin
        if (status_i.acc_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.elem_last = (r_q == rows_m1_i) && (c_q == dim_m1_i);
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          if (cmd_o.elem_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (c_q == dim_m1_i) begin
              c_d = '0;
              r_d = r_q + cnt_t'(1);
            end else begin
              c_d = c_q + cnt_t'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

endmodule

### rtl/core/psmm_dp.sv
module psmm_dp #(
  parameter int MAX_N = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psmm_pkg::cmd_t          cmd_i,
  output psmm_pkg::status_t       status_o,
  input  psmm_pkg::cnt_t          row_sel_i,
  input  psmm_pkg::cnt_t          col_sel_i,
  input  logic [7:0]              list_index_i,
  input  logic [31:0]             value_i,
  input  logic [7:0]              list_offset_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output psmm_pkg::cnt_t          out_row_o,
  output psmm_pkg::cnt_t          out_col_o,
  output logic [31:0]             out_value_o,
  output logic                    out_last_o
);
  import psmm_pkg::*;

  localparam int LDEPTH = MAX_N * MAX_N;
  localparam int PDEPTH = MAX_N * (MAX_N + 1) / 2;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int ACC_W  = 64 + $clog2(MAX_N);
  localparam int SH_W   = ACC_W - 16;

  logic [LAW-1:0] l_waddr, l_raddr;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic           l_we, p_we;
  logic [8:0]     slot;
  cnt_t           hi, lo;
  logic [31:0]    l_rdata, p_rdata;

  // left matrix writes
  assign l_we    = cmd_i.wr_left && (int'(row_sel_i) < MAX_N) && (int'(col_sel_i) < MAX_N);
  assign l_waddr = LAW'(int'(row_sel_i) * MAX_N + int'(col_sel_i));

  // packed triangle writes, slot relative to list offset
  assign slot    = {1'b0, list_index_i} - {1'b0, list_offset_i};
  assign p_we    = cmd_i.wr_sym && !slot[8] && (int'(slot[7:0]) < PDEPTH);
  assign p_waddr = PAW'(slot[7:0]);

  // read addresses, sym[k][c] from the lower triangle
  assign hi      = (cmd_i.k >= cmd_i.c) ? cmd_i.k : cmd_i.c;
  assign lo      = (cmd_i.k >= cmd_i.c) ? cmd_i.c : cmd_i.k;
  assign l_raddr = LAW'(int'(cmd_i.r) * MAX_N + int'(cmd_i.k));
  assign p_raddr = PAW'(int'(tri_base(hi)) + int'(lo));

  psmm_ram #(.WIDTH(VAL_W), .DEPTH(LDEPTH)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(value_i),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  psmm_ram #(.WIDTH(VAL_W), .DEPTH(PDEPTH)) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(value_i),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // pipeline: ram read -> multiply -> accumulate
  logic                    v2_q, f2_q, l2_q;
  logic                    v3_q, f3_q, l3_q;
  logic signed [63:0]      prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SH_W-1:0]  sh;
  logic [31:0]             sat;

  assign prod_d = $signed(l_rdata) * $signed(p_rdata);
  assign acc_d  = (f3_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= cmd_i.rd;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q <= cmd_i.k_first;
    l2_q <= cmd_i.k_last;
    f3_q <= f2_q;
    l3_q <= l2_q;
    if (v2_q) begin
      prod_q <= prod_d;
    end
    if (v3_q) begin
      acc_q <= acc_d;
    end
  end

  assign status_o.acc_done = v3_q && l3_q;

  // floor shift, then saturate to 32 bits
  assign sh = SH_W'(acc_q >>> 16);
  always_comb begin
    if ((&sh[SH_W-1:31]) || !(|sh[SH_W-1:31])) begin
      sat = sh[31:0];
    end else if (sh[SH_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7fff_ffff;
    end
  end

  // output register
  logic out_valid_q;

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_row_o   <= cmd_i.r;
      out_col_o   <= cmd_i.c;
      out_value_o <= sat;
      out_last_o  <= cmd_i.elem_last;
    end
  end

endmodule
